### rtl/core/utf8tc_pkg.sv
// shared types and constants of the utf-16 to utf-8 transcoder
package utf8tc_pkg;

  localparam int CAP_W   = 20;
  localparam int TOTAL_W = 20;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;

  localparam logic CFG_EMIT_BYTES   = 1'b0;
  localparam logic CFG_OUT_CAPACITY = 1'b1;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNPAIRED = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // one queued work item: up to four data bytes and an optional summary
  typedef struct packed {
    logic [3:0][7:0]      bytes;
    logic [2:0]           nbytes;
    logic [TOTAL_W-1:0]   base;
    logic                 summary;
    logic [TOTAL_W-1:0]   sum_total;
    status_t              sum_status;
    logic                 sum_fits;
  } job_t;

endpackage

### rtl/core/utf8tc_front.sv
// front end: surrogate pairing, encoding, byte count and capacity check
module utf8tc_front #(
  parameter int COUNT_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [utf8tc_pkg::CAP_W-1:0]  cfg_data,
  input  logic                          in_fire,
  input  logic [15:0]                   in_unit,
  input  logic                          in_last,
  output logic                          push,
  output utf8tc_pkg::job_t              push_job
);

  localparam int LW = (COUNT_BITS > utf8tc_pkg::CAP_W) ? COUNT_BITS : utf8tc_pkg::CAP_W;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
  } enc_t;

  logic                          emit_bytes_r;
  logic [utf8tc_pkg::CAP_W-1:0]  out_capacity_r;
  logic [9:0]                    held_high_r, held_high_nxt;
  logic                          held_valid_r, held_valid_nxt;
  logic [COUNT_BITS-1:0]         byte_count_r, byte_count_nxt;
  utf8tc_pkg::status_t           error_r, error_nxt, err_upd;
  logic [COUNT_BITS-1:0]         count_upd;

  logic        is_high, is_low, have_cp, ovf, emit_data;
  logic [20:0] cp;
  enc_t        enc;
  logic [LW-1:0] cmax, capx, lim;
  logic [LW:0]   sum;

  function automatic enc_t encode(input logic [20:0] c);
    enc_t e;
    e.bytes = '0;
    if (c <= 21'h7F) begin
      e.bytes[0] = c[7:0];
      e.n = 3'd1;
    end else if (c <= 21'h7FF) begin
      e.bytes[0] = {3'b110, c[10:6]};
      e.bytes[1] = {2'b10, c[5:0]};
      e.n = 3'd2;
    end else if (c <= 21'hFFFF) begin
      e.bytes[0] = {4'b1110, c[15:12]};
      e.bytes[1] = {2'b10, c[11:6]};
      e.bytes[2] = {2'b10, c[5:0]};
      e.n = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, c[20:18]};
      e.bytes[1] = {2'b10, c[17:12]};
      e.bytes[2] = {2'b10, c[11:6]};
      e.bytes[3] = {2'b10, c[5:0]};
      e.n = 3'd4;
    end
    return e;
  endfunction

  always_comb begin
    is_high        = (in_unit[15:10] == 6'b110110);
    is_low         = (in_unit[15:10] == 6'b110111);
    have_cp        = 1'b0;
    cp             = '0;
    held_high_nxt  = held_high_r;
    held_valid_nxt = held_valid_r;
    err_upd        = error_r;
    if (error_r == utf8tc_pkg::ST_OK) begin
      if (held_valid_r) begin
        if (is_low) begin
          cp      = {1'b0, held_high_r, in_unit[9:0]} + 21'h10000;
          have_cp = 1'b1;
        end else begin
          err_upd = utf8tc_pkg::ST_UNPAIRED;
        end
        held_valid_nxt = 1'b0;
        held_high_nxt  = '0;
      end else if (is_high) begin
        if (in_last) begin
          err_upd = utf8tc_pkg::ST_UNPAIRED;
        end else begin
          held_high_nxt  = in_unit[9:0];
          held_valid_nxt = 1'b1;
        end
      end else begin
        cp      = {5'd0, in_unit};
        have_cp = 1'b1;
      end
    end

    enc  = encode(cp);
    cmax = LW'({COUNT_BITS{1'b1}});
    capx = LW'(out_capacity_r);
    lim  = (emit_bytes_r && (capx < cmax)) ? capx : cmax;
    sum  = (LW+1)'(byte_count_r) + (LW+1)'(enc.n);
    ovf  = have_cp && (sum > {1'b0, lim});

    count_upd = byte_count_r;
    if (have_cp) begin
      if (ovf) begin
        err_upd = utf8tc_pkg::ST_OVERFLOW;
      end else begin
        count_upd = COUNT_BITS'(sum);
      end
    end
    emit_data = have_cp && !ovf && emit_bytes_r;

    push_job.bytes      = enc.bytes;
    push_job.nbytes     = emit_data ? enc.n : 3'd0;
    push_job.base       = utf8tc_pkg::TOTAL_W'(byte_count_r);
    push_job.summary    = in_last;
    push_job.sum_total  = (err_upd != utf8tc_pkg::ST_OK) ? '0
                          : utf8tc_pkg::TOTAL_W'(count_upd);
    push_job.sum_status = err_upd;
    push_job.sum_fits   = emit_bytes_r && (err_upd == utf8tc_pkg::ST_OK)
                          && (LW'(count_upd) < capx);
    push = in_fire && (emit_data || in_last);

    byte_count_nxt = count_upd;
    error_nxt      = err_upd;
    if (in_last) begin
      held_high_nxt  = '0;
      held_valid_nxt = 1'b0;
      byte_count_nxt = '0;
      error_nxt      = utf8tc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_bytes_r   <= 1'b1;
      out_capacity_r <= '1;
      held_high_r    <= '0;
      held_valid_r   <= 1'b0;
      byte_count_r   <= '0;
      error_r        <= utf8tc_pkg::ST_OK;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          utf8tc_pkg::CFG_EMIT_BYTES:   emit_bytes_r   <= cfg_data[0];
          utf8tc_pkg::CFG_OUT_CAPACITY: out_capacity_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        held_high_r  <= held_high_nxt;
        held_valid_r <= held_valid_nxt;
        byte_count_r <= byte_count_nxt;
        error_r      <= error_nxt;
      end
    end
  end

endmodule

### rtl/core/utf8tc_queue.sv
// four-entry work queue between front and back end
module utf8tc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  utf8tc_pkg::job_t  push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output utf8tc_pkg::job_t  head_job
);

  utf8tc_pkg::job_t                mem_r [utf8tc_pkg::QDEPTH];
  logic [utf8tc_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [utf8tc_pkg::QPTR_W:0]     fill_r;

  assign full       = (fill_r == (utf8tc_pkg::QPTR_W+1)'(utf8tc_pkg::QDEPTH));
  assign head_valid = (fill_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

### rtl/core/utf8tc_back.sv
// back end: walks the queued bytes and summary into the result register
module utf8tc_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            head_valid,
  input  utf8tc_pkg::job_t                head_job,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [7:0]                      out_byte,
  output logic [utf8tc_pkg::TOTAL_W-1:0]  out_total,
  output utf8tc_pkg::status_t             out_status,
  output logic                            out_fits,
  output logic                            out_last
);

  logic [2:0]                     idx_r;
  logic                           out_valid_r;
  logic                           kind_r, fits_r, last_r;
  logic [7:0]                     byte_r;
  logic [utf8tc_pkg::TOTAL_W-1:0] total_r;
  utf8tc_pkg::status_t            status_r;

  logic load, is_data, done;

  always_comb begin
    load    = head_valid && (!out_valid_r || out_ready);
    is_data = (idx_r < head_job.nbytes);
    done    = is_data ? ((idx_r == head_job.nbytes - 3'd1) && !head_job.summary) : 1'b1;
    pop     = load && done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= done ? 3'd0 : idx_r + 3'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_r <= done;
      if (is_data) begin
        kind_r   <= utf8tc_pkg::KIND_DATA;
        byte_r   <= head_job.bytes[idx_r[1:0]];
        total_r  <= head_job.base + utf8tc_pkg::TOTAL_W'(idx_r) + 1'b1;
        status_r <= utf8tc_pkg::ST_OK;
        fits_r   <= 1'b0;
      end else begin
        kind_r   <= utf8tc_pkg::KIND_SUMMARY;
        byte_r   <= 8'd0;
        total_r  <= head_job.sum_total;
        status_r <= head_job.sum_status;
        fits_r   <= head_job.sum_fits;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = kind_r;
  assign out_byte   = byte_r;
  assign out_total  = total_r;
  assign out_status = status_r;
  assign out_fits   = fits_r;
  assign out_last   = last_r;

endmodule

### rtl/core/utf16_to_utf8_transcoder_top.sv
// top level of the utf-16 to utf-8 transcoder
//
//  channel  | direction | payload
//  in_*     | slave     | tdata[15:0] code_unit, tlast last_unit
//  out_*    | master    | tdata byte/total/status/nul_fits, tuser kind, tlast is_last
//  cfg_*    | write     | index 0 emit_bytes, index 1 out_capacity
//
// one result per cycle while out_tready is high: a unit gives 0 to 4 byte transfers plus 1
// summary transfer on the last unit, each on the one-byte result port
// a unit is accepted every cycle while the four-entry work queue has room
// results pass through the work queue and then the registered result stage
// reset is synchronous and clears all string state; registers return to defaults
// a stalled result port fills the queue and then holds off input
module utf16_to_utf8_transcoder_top #(
  parameter int COUNT_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [15:0] code_unit
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // out_byte, total_bytes, status, nul_fits
  output logic                          out_tuser,  // kind
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [utf8tc_pkg::CAP_W-1:0]  cfg_data
);

  logic                            in_fire, push, full, pop, head_valid;
  utf8tc_pkg::job_t                push_job, head_job;
  logic [7:0]                      o_byte;
  logic [utf8tc_pkg::TOTAL_W-1:0]  o_total;
  utf8tc_pkg::status_t             o_status;
  logic                            o_fits;

  assign in_tready = !full;
  assign in_fire   = in_tvalid && in_tready;

  utf8tc_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .in_unit   (in_tdata),
    .in_last   (in_tlast),
    .push      (push),
    .push_job  (push_job)
  );

  utf8tc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  utf8tc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_byte   (o_byte),
    .out_total  (o_total),
    .out_status (o_status),
    .out_fits   (o_fits),
    .out_last   (out_tlast)
  );

  assign out_tdata = {1'b0, o_fits, o_status, o_total, o_byte};

endmodule

### rtl/core/utf8tc_checker.sv
// port-level checks on the result channel, bound to the top level
module utf8tc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // stalled transfer holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
    && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata[7:0] == 8'd0))
    else $error("summary without tlast or with nonzero byte");

  a_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata[30:28] == 3'd0))
    else $error("data transfer with status or nul_fits");

  a_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[30] |-> (out_tdata[29:28] == 2'd0))
    else $error("nul_fits with error status");

endmodule

bind utf16_to_utf8_transcoder_top utf8tc_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

### bench/utf16_to_utf8_transcoder_top_tb.sv
// testbench for the utf-16 to utf-8 transcoder: predicting scoreboard, stream drivers and checks

typedef struct {
  logic                 kind;
  logic [7:0]           data_byte;
  logic [19:0]          total;
  utf8tc_pkg::status_t  status;
  logic                 nul_fits;
  logic                 is_last;
} utf8_result_t;

class utf8_scoreboard;
  bit                   emit_bytes;
  bit [19:0]            capacity;
  bit [9:0]             held_high;
  bit                   held_valid;
  int unsigned          byte_count;
  utf8tc_pkg::status_t  string_status;
  utf8_result_t         pending_q[$];
  int                   failures;

  function new();
    emit_bytes = 1'b1;
    capacity = 20'hFFFFF;
    failures = 0;
    clear_string();
  endfunction

  function void clear_string();
    held_high = '0;
    held_valid = 1'b0;
    byte_count = 0;
    string_status = utf8tc_pkg::ST_OK;
  endfunction

  function void set_regs(bit emit, bit [19:0] cap);
    emit_bytes = emit;
    capacity = cap;
  endfunction

  function void push(logic kind, logic [7:0] b, int unsigned total,
                     utf8tc_pkg::status_t st, logic fits, logic fin);
    utf8_result_t r;
    r.kind = kind;
    r.data_byte = b;
    r.total = total[19:0];
    r.status = st;
    r.nul_fits = fits;
    r.is_last = fin;
    pending_q.push_back(r);
  endfunction

  // work out the transfers one accepted code unit causes
  function void note_unit(logic [15:0] unit, logic last);
    logic [20:0]     cp;
    logic            have_cp;
    logic [3:0][7:0] enc;
    int              n;
    int unsigned     limit;
    bit              is_high;
    bit              is_low;
    have_cp = 1'b0;
    cp = '0;
    enc = '0;
    n = 0;
    is_high = unit >= 16'hD800 && unit <= 16'hDBFF;
    is_low = unit >= 16'hDC00 && unit <= 16'hDFFF;
    if (string_status == utf8tc_pkg::ST_OK) begin
      if (held_valid) begin
        if (is_low) begin
          cp = 21'h10000 + {1'b0, held_high, unit[9:0]};
          have_cp = 1'b1;
        end else begin
          string_status = utf8tc_pkg::ST_UNPAIRED;
        end
        held_valid = 1'b0;
        held_high = '0;
      end else if (is_high) begin
        if (last) begin
          string_status = utf8tc_pkg::ST_UNPAIRED;
        end else begin
          held_high = unit[9:0];
          held_valid = 1'b1;
        end
      end else begin
        cp = {5'd0, unit};
        have_cp = 1'b1;
      end
    end
    if (have_cp) begin
      if (cp <= 21'h7F) begin
        n = 1;
        enc[0] = cp[7:0];
      end else if (cp <= 21'h7FF) begin
        n = 2;
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hFFFF) begin
        n = 3;
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end else begin
        n = 4;
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
      limit = 32'h000FFFFF;
      if (emit_bytes && capacity < limit) limit = capacity;
      if (byte_count + n > limit) begin
        string_status = utf8tc_pkg::ST_OVERFLOW;
      end else if (emit_bytes) begin
        for (int i = 0; i < n; i++) begin
          byte_count++;
          push(utf8tc_pkg::KIND_DATA, enc[i], byte_count, utf8tc_pkg::ST_OK, 1'b0,
               (i == n - 1) && !last);
        end
      end else begin
        byte_count += n;
      end
    end
    if (last) begin
      push(utf8tc_pkg::KIND_SUMMARY, 8'h00,
           (string_status == utf8tc_pkg::ST_OK) ? byte_count : 0, string_status,
           emit_bytes && string_status == utf8tc_pkg::ST_OK && byte_count < capacity, 1'b1);
      clear_string();
    end
  endfunction

  function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      failures++;
    end
  endfunction

  function void check_result(logic [31:0] tdata, logic tuser, logic tlast);
    utf8_result_t exp_r;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected transfer, expected none, actual tdata %h tuser %b tlast %b",
               $time, tdata, tuser, tlast);
      failures++;
      return;
    end
    exp_r = pending_q.pop_front();
    compare("kind", exp_r.kind, tuser);
    compare("out_byte", exp_r.data_byte, tdata[7:0]);
    compare("total_bytes", exp_r.total, tdata[27:8]);
    compare("status", exp_r.status, tdata[29:28]);
    compare("nul_fits", exp_r.nul_fits, tdata[30]);
    compare("is_last", exp_r.is_last, tlast);
  endfunction
endclass

module utf16_to_utf8_transcoder_top_tb;
  localparam int          STALL_LIMIT = 2000;
  localparam int          LONG_HOLD   = 300;
  localparam int          DRAIN_WAIT  = 20;
  localparam logic [19:0] CAP_MAX     = 20'hFFFFF;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [15:0]                   in_tdata = '0;   // [15:0] code_unit
  logic                          in_tlast = 1'b0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [31:0]                   out_tdata;       // [7:0] out_byte, [27:8] total_bytes,
                                                  // [29:28] status, [30] nul_fits
  logic                          out_tuser;       // [0] kind
  logic                          out_tlast;
  logic                          cfg_we = 1'b0;
  logic                          cfg_index = 1'b0;
  logic [utf8tc_pkg::CAP_W-1:0]  cfg_data = '0;

  utf8_scoreboard sb = new();
  bit             calm_tx = 1'b0;
  logic [15:0]    string_q[$];

  utf16_to_utf8_transcoder_top dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_unit(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stalls, one long hold-off, and a stretch with no stalls
  initial begin : receiver
    int  taken;
    int  hold;
    bit  held_once;
    taken = 0;
    hold = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) taken++;
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (!held_once && taken >= 60) begin
        held_once = 1'b1;
        hold = LONG_HOLD;
        out_tready <= 1'b0;
      end else begin
        out_tready <= (taken >= 150 && taken < 300) || ($urandom_range(99) >= 17);
      end
    end
  end

  task automatic send_unit(input logic [15:0] unit, input logic last);
    if (!calm_tx && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 17);
    end
    in_tvalid <= 1'b1;
    in_tdata <= unit;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // wait out every expected transfer, then the queue latency
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_regs(input bit emit, input logic [19:0] cap);
    cfg_we <= 1'b1;
    cfg_index <= utf8tc_pkg::CFG_EMIT_BYTES;
    cfg_data <= {19'd0, emit};
    @(posedge clk);
    cfg_index <= utf8tc_pkg::CFG_OUT_CAPACITY;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_regs(emit, cap);
  endtask

  task automatic build_string();
    int len;
    int pick;
    int spot;
    string_q.delete();
    len = $urandom_range(1, 8);
    while (string_q.size() < len) begin
      pick = $urandom_range(9);
      case (pick)
        0, 1, 2: begin
          string_q.push_back(16'($urandom_range(0, 16'h007F)));
        end
        3: begin
          string_q.push_back(16'($urandom_range(16'h0080, 16'h07FF)));
        end
        4, 5: begin
          if ($urandom_range(1)) string_q.push_back(16'($urandom_range(16'h0800, 16'hD7FF)));
          else string_q.push_back(16'($urandom_range(16'hE000, 16'hFFFF)));
        end
        6, 7: begin
          string_q.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
          string_q.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end
        8: begin
          string_q.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end
        default: begin
          string_q.push_back(16'($urandom_range(0, 16'hFFFF)));
        end
      endcase
    end
    // broken string: a stray high surrogate, possibly at the end
    if ($urandom_range(99) < 15) begin
      spot = $urandom_range(0, string_q.size());
      string_q.insert(spot, 16'($urandom_range(16'hD800, 16'hDBFF)));
    end
  endtask

  task automatic flush_string();
    foreach (string_q[i]) send_unit(string_q[i], i == string_q.size() - 1);
  endtask

  initial begin : stimulus
    int          phase_units;
    bit          emit;
    logic [19:0] cap;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // encoding edges and surrogate handling under reset defaults
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0042, 1'b0);
    send_unit(16'h0043, 1'b1);
    send_unit(16'hDBFF, 1'b1);
    send_unit(16'hD801, 1'b0);
    send_unit(16'hD802, 1'b1);
    settle();

    // capacity edges
    write_regs(1'b1, 20'd0);
    send_unit(16'h0041, 1'b1);
    settle();
    write_regs(1'b1, 20'd3);
    send_unit(16'h0800, 1'b1);
    settle();
    write_regs(1'b1, 20'd4);
    send_unit(16'h0800, 1'b0);
    send_unit(16'h0080, 1'b1);
    settle();

    // count only mode
    write_regs(1'b0, 20'd0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hD83D, 1'b0);
    send_unit(16'hDE00, 1'b1);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'h0041, 1'b1);
    settle();

    for (int p = 0; p < 8; p++) begin
      emit = (p == 0) || ($urandom_range(3) != 0);
      case ($urandom_range(2))
        0: cap = CAP_MAX;
        1: cap = 20'($urandom_range(0, 48));
        default: cap = 20'($urandom_range(0, CAP_MAX));
      endcase
      if (p == 0) cap = CAP_MAX;
      write_regs(emit, cap);
      calm_tx = (p == 3);
      phase_units = 0;
      while (phase_units < 36) begin
        build_string();
        phase_units += string_q.size();
        flush_string();
      end
      settle();
    end

    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
